[src/pip_pkg.sv]
// Shared types and codes for the point-in-polygon test block.
// Used by pip_ctrl, pip_datapath and point_in_polygon_test; depends on nothing.
package pip_pkg;

  // Operation codes of an input word.
  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  // Unused code: the word is taken and ignored.
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Controller states, one-hot.
  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_START = 9'b000000010,
    ST_LOAD0 = 9'b000000100,
    ST_LOADB = 9'b000001000,
    ST_MUL1  = 9'b000010000,
    ST_MUL2  = 9'b000100000,
    ST_MUL3  = 9'b001000000,
    ST_EVAL  = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  // Which cross-product term the shared multiplier forms.
  typedef enum logic [1:0] {
    MUL_P1 = 2'd0,
    MUL_P2 = 2'd1,
    MUL_P3 = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     start_poly;
    logic     append;
    logic     query;
    logic     rd_first;
    logic     ld_first;
    logic     ld_b;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     eval;
    logic     advance;
    logic     res_load;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic one_vtx;
    logic onseg;
    logic last;
    logic wrap;
  } status_t;

endpackage

[src/pip_ctrl.sv]
// Sequencer for the point-in-polygon test: handshakes and edge walk control.
// Depends on pip_pkg.
module pip_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       operation,
  output logic             out_valid,
  input  logic             out_stall,
  input  pip_pkg::status_t st,
  output pip_pkg::cmd_t    cmd
);

  pip_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pip_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != pip_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = pip_pkg::MUL_P1;
    case (state)
      pip_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (operation)
            pip_pkg::OP_START:  cmd.start_poly = 1'b1;
            pip_pkg::OP_APPEND: cmd.append = 1'b1;
            pip_pkg::OP_QUERY: begin
              cmd.query = 1'b1;
              state_next = pip_pkg::ST_START;
            end
            default: ;
          endcase
        end
      end
      pip_pkg::ST_START: begin
        if (st.count_zero) begin
          state_next = pip_pkg::ST_DONE;
        end else begin
          cmd.rd_first = 1'b1;
          state_next = pip_pkg::ST_LOAD0;
        end
      end
      pip_pkg::ST_LOAD0: begin
        cmd.ld_first = 1'b1;
        state_next = st.one_vtx ? pip_pkg::ST_MUL1 : pip_pkg::ST_LOADB;
      end
      pip_pkg::ST_LOADB: begin
        cmd.ld_b = 1'b1;
        state_next = pip_pkg::ST_MUL1;
      end
      pip_pkg::ST_MUL1: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pip_pkg::MUL_P1;
        state_next = pip_pkg::ST_MUL2;
      end
      pip_pkg::ST_MUL2: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pip_pkg::MUL_P2;
        state_next = pip_pkg::ST_MUL3;
      end
      pip_pkg::ST_MUL3: begin
        cmd.mul_en = 1'b1;
        cmd.mul_sel = pip_pkg::MUL_P3;
        state_next = pip_pkg::ST_EVAL;
      end
      pip_pkg::ST_EVAL: begin
        cmd.eval = 1'b1;
        if (st.onseg || st.last) begin
          state_next = pip_pkg::ST_DONE;
        end else begin
          cmd.advance = 1'b1;
          state_next = st.wrap ? pip_pkg::ST_MUL1 : pip_pkg::ST_LOADB;
        end
      end
      pip_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.res_load = 1'b1;
          state_next = pip_pkg::ST_IDLE;
        end
      end
      default: state_next = pip_pkg::ST_IDLE;
    endcase
  end

endmodule

[src/pip_datapath.sv]
// Datapath of the point-in-polygon test: vertex memory, edge registers,
// shared multiplier and crossing logic. Depends on pip_pkg.
module pip_datapath #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pip_pkg::cmd_t                cmd,
  output pip_pkg::status_t             st,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         inside_res,
  output logic                         vertices_dropped
);

  localparam int AW  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int DDW = PW + 1;
  localparam logic signed [DW-1:0] RAY_X = {2'b11, {(COORD_BITS-1){1'b0}}};
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VERTICES);

  logic [2*COORD_BITS-1:0] mem [MAX_VERTICES];
  logic [2*COORD_BITS-1:0] rdata;
  logic [AW-1:0]           raddr, waddr;
  logic [CW-1:0]           count, nxt, nxt_inc;
  logic                    ovf;

  logic signed [COORD_BITS-1:0] px, py, ax, ay, bx, by, fx, fy, rx, ry;
  logic                         closing, par, res_bit;
  logic signed [DW-1:0]         op_l, op_r;
  logic signed [PW-1:0]         prod, p1, p2;
  logic signed [DDW-1:0]        d1, d2;
  logic                         few_vtx, onseg, hz, a_on, b_on, meet, inc;
  logic                         d1_pos, d1_neg, d2_pos, d2_neg;

  assign rx = rdata[2*COORD_BITS-1:COORD_BITS];
  assign ry = rdata[COORD_BITS-1:0];
  assign nxt_inc = nxt + 1'b1;
  assign waddr = cmd.start_poly ? '0 : count[AW-1:0];
  assign raddr = cmd.rd_first ? '0 : (cmd.ld_first ? AW'(1) : nxt_inc[AW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.start_poly || (cmd.append && count < MAX_CNT)) begin
      mem[waddr] <= {coord_x, coord_y};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.start_poly) begin
      count <= CW'(1);
      ovf   <= 1'b0;
    end else if (cmd.append) begin
      if (count < MAX_CNT) begin
        count <= count + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // Multiplier operands for the three cross-product terms.
  always_comb begin
    case (cmd.mul_sel)
      pip_pkg::MUL_P1: begin
        op_l = DW'(px) - DW'(ax);
        op_r = DW'(by) - DW'(ay);
      end
      pip_pkg::MUL_P2: begin
        op_l = DW'(bx) - DW'(ax);
        op_r = DW'(py) - DW'(ay);
      end
      pip_pkg::MUL_P3: begin
        op_l = RAY_X - DW'(ax);
        op_r = DW'(by) - DW'(ay);
      end
      default: begin
        op_l = '0;
        op_r = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      px <= coord_x;
      py <= coord_y;
    end
    if (cmd.ld_first) begin
      fx <= rx;
      fy <= ry;
      ax <= rx;
      ay <= ry;
      bx <= rx;
      by <= ry;
      nxt <= CW'(1);
      closing <= 1'b0;
    end
    if (cmd.ld_b) begin
      bx <= rx;
      by <= ry;
    end
    if (cmd.advance) begin
      ax  <= bx;
      ay  <= by;
      nxt <= nxt_inc;
      if (nxt_inc == count) begin
        bx <= fx;
        by <= fy;
        closing <= 1'b1;
      end
    end
    if (cmd.mul_en) begin
      prod <= op_l * op_r;
      if (cmd.mul_sel == pip_pkg::MUL_P2) begin
        p1 <= prod;
      end
      if (cmd.mul_sel == pip_pkg::MUL_P3) begin
        p2 <= prod;
        d1 <= DDW'(p1) - DDW'(prod);
      end
    end
    if (cmd.res_load) begin
      inside_res       <= res_bit;
      vertices_dropped <= ovf;
    end
  end

  // d1 is the orientation of (a, b, p) negated; d2 pairs it for the ray test.
  assign d2     = DDW'(p2) - DDW'(prod);
  assign d1_neg = d1[DDW-1];
  assign d1_pos = !d1[DDW-1] && (d1 != '0);
  assign d2_neg = d2[DDW-1];
  assign d2_pos = !d2[DDW-1] && (d2 != '0);

  assign few_vtx = (count <= CW'(2));
  assign onseg = (d1 == '0) &&
                 ((px >= ax && px <= bx) || (px >= bx && px <= ax)) &&
                 ((py >= ay && py <= by) || (py >= by && py <= ay));
  assign hz   = (ay == by);
  assign a_on = (ay == py) && (ax <= px);
  assign b_on = (by == py) && (bx <= px);
  assign meet = (px >= ax || px >= bx) &&
                ((py >= ay && py <= by) || (py >= by && py <= ay)) &&
                !((d1_pos && d2_neg) || (d1_neg && d2_pos));
  assign inc  = !hz && (a_on ? (ay > by) : (b_on ? (by > ay) : meet));

  always_ff @(posedge clk) begin
    if (cmd.query) begin
      par     <= 1'b0;
      res_bit <= 1'b0;
    end else if (cmd.eval) begin
      par     <= par ^ inc;
      res_bit <= onseg || (!few_vtx && (par ^ inc));
    end
  end

  assign st.count_zero = (count == '0);
  assign st.one_vtx    = (count == CW'(1));
  assign st.onseg      = onseg;
  assign st.last       = few_vtx || closing;
  assign st.wrap       = (nxt_inc == count);

endmodule

[src/point_in_polygon_test.sv]
// Point-in-polygon test. Start and append words are taken while idle.
// A query over N >= 3 vertices passes the start and first-load states, then per edge a
// vertex load, three passes of the one multiplier and an evaluate (the closing
// edge has no load), and ends in the output state that registers the result.
// With no vertex the walk is skipped; fewer than three test a single edge. An
// on-edge point ends the walk early; a stalled output holds the output state.
// Reset (rst, synchronous) empties the polygon and clears the drop flag.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         inside_res,
  output logic                         vertices_dropped
);

  // The controller walks the polygon edges one at a time. Each edge is
  // tested for containing the point and for crossing the leftward ray
  // from the point, using signs of exact cross products and coordinate comparisons.
  pip_pkg::cmd_t    cmd;
  pip_pkg::status_t st;

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the vertex memory, the edge registers, and the
  // output word register, so a finished result can wait for the consumer.
  pip_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .coord_x          (coord_x),
    .coord_y          (coord_y),
    .inside_res       (inside_res),
    .vertices_dropped (vertices_dropped)
  );

endmodule
